// ===== rtl/b64_pkg.sv =====
// Package for the Base64 codec: command word type, character constants
// and the alphabet mapping functions. No dependencies.
`default_nettype none

package b64_pkg;

  // Character codes.
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
  localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_SLASH   = 8'h2F;
  localparam logic [7:0] CHAR_PAD     = 8'h3D;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  // Command queue between front and back.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    KIND_ENC = 2'd0,  // four characters, trailing pads replaced by '='
    KIND_DEC = 2'd1,  // three bytes less one per pad
    KIND_ERR = 2'd2   // one bad word
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic        last;
    logic [1:0]  pads;
    logic [23:0] bits;
  } cmd_t;

  // Sextet value to alphabet character.
  function automatic logic [7:0] char_of(input logic [5:0] v);
    logic [7:0] v8;
    v8 = {2'b00, v};
    if (v < 6'd26) begin
      char_of = CHAR_UPPER_A + v8;
    end else if (v < 6'd52) begin
      char_of = CHAR_LOWER_A + v8 - 8'd26;
    end else if (v < 6'd62) begin
      char_of = CHAR_DIGIT_0 + v8 - 8'd52;
    end else if (v == 6'd62) begin
      char_of = CHAR_PLUS;
    end else begin
      char_of = CHAR_SLASH;
    end
  endfunction

  // Character to sextet; bit 6 set when the character is not in the alphabet.
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [7:0] diff;
    diff = 8'd0;
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      diff = c - CHAR_UPPER_A;
      sextet_of = {1'b0, diff[5:0]};
    end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
      diff = c - CHAR_LOWER_A + 8'd26;
      sextet_of = {1'b0, diff[5:0]};
    end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
      diff = c - CHAR_DIGIT_0 + 8'd52;
      sextet_of = {1'b0, diff[5:0]};
    end else if (c == CHAR_PLUS) begin
      sextet_of = {1'b0, 6'd62};
    end else if (c == CHAR_SLASH) begin
      sextet_of = {1'b0, 6'd63};
    end else begin
      sextet_of = {1'b1, 6'd0};
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/b64_front.sv =====
// Front end of the Base64 codec: takes input words, gathers groups and
// issues one command per finished group. Depends on b64_pkg.
`default_nettype none

module b64_front (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              mode,
  input  wire              clr,
  input  wire              in_valid,
  input  wire  [7:0]       in_data,
  input  wire              in_last,
  input  wire              q_full,
  output logic             in_ready,
  output logic             push,
  output b64_pkg::cmd_t    push_cmd
);

  logic [17:0] held_r, held_nxt;
  logic [1:0]  gc_r, gc_nxt;
  logic [1:0]  pad_r, pad_nxt;

  logic        accept;
  logic        emit;
  logic [6:0]  sx;
  logic        is_pad;
  logic        ok;
  logic [1:0]  pads_n;
  logic [5:0]  val;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign sx       = b64_pkg::sextet_of(in_data);
  assign is_pad   = (in_data == b64_pkg::CHAR_PAD);

  always_comb begin
    if (is_pad) begin
      ok     = (gc_r >= 2'd2);
      pads_n = pad_r + 2'd1;
      val    = 6'd0;
    end else begin
      ok     = !sx[6] && (pad_r == 2'd0);
      pads_n = pad_r;
      val    = sx[5:0];
    end
  end

  always_comb begin
    emit          = 1'b0;
    push_cmd.kind = b64_pkg::KIND_ERR;
    push_cmd.last = in_last;
    push_cmd.pads = 2'd0;
    push_cmd.bits = 24'd0;
    held_nxt      = held_r;
    gc_nxt        = gc_r;
    pad_nxt       = pad_r;
    if (mode == b64_pkg::MODE_ENCODE) begin
      push_cmd.kind = b64_pkg::KIND_ENC;
      if (gc_r == 2'd2) begin
        emit          = 1'b1;
        push_cmd.bits = {held_r[15:0], in_data};
      end else if (in_last) begin
        emit = 1'b1;
        if (gc_r == 2'd0) begin
          push_cmd.bits = {in_data, 16'd0};
          push_cmd.pads = 2'd2;
        end else begin
          push_cmd.bits = {held_r[7:0], in_data, 8'd0};
          push_cmd.pads = 2'd1;
        end
      end else begin
        held_nxt = {held_r[9:0], in_data};
        gc_nxt   = gc_r + 2'd1;
      end
    end else begin
      if (!ok) begin
        emit = 1'b1;
      end else if (gc_r == 2'd3) begin
        emit          = 1'b1;
        push_cmd.kind = b64_pkg::KIND_DEC;
        push_cmd.pads = pads_n;
        push_cmd.bits = {held_r, val};
      end else if (in_last) begin
        // short final group
        emit          = 1'b1;
        push_cmd.last = 1'b1;
      end else begin
        held_nxt = {held_r[11:0], val};
        gc_nxt   = gc_r + 2'd1;
        pad_nxt  = pads_n;
      end
    end
    if (emit) begin
      held_nxt = 18'd0;
      gc_nxt   = 2'd0;
      pad_nxt  = 2'd0;
    end
  end

  assign push = accept && emit;

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      held_r <= 18'd0;
      gc_r   <= 2'd0;
      pad_r  <= 2'd0;
    end else if (accept) begin
      held_r <= held_nxt;
      gc_r   <= gc_nxt;
      pad_r  <= pad_nxt;
    end
  end

  // A group never carries more than two pads before it completes.
  a_pad_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pad_r != 2'd3)
    else $error("pad count out of range");

endmodule

`default_nettype wire

// ===== rtl/b64_queue.sv =====
// Short command queue between front and back of the Base64 codec.
// Depends on b64_pkg.
`default_nettype none

module b64_queue (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              push,
  input  b64_pkg::cmd_t    push_cmd,
  input  wire              pop,
  output b64_pkg::cmd_t    head,
  output logic             empty,
  output logic             full
);

  localparam logic [b64_pkg::QPTR_W-1:0] PTR_LAST = b64_pkg::QPTR_W'(b64_pkg::QDEPTH - 1);
  localparam logic [b64_pkg::QCNT_W-1:0] CNT_FULL = b64_pkg::QCNT_W'(b64_pkg::QDEPTH);

  b64_pkg::cmd_t              mem_r [b64_pkg::QDEPTH];
  logic [b64_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [b64_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [b64_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == CNT_FULL);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("pop from empty queue");

endmodule

`default_nettype wire

// ===== rtl/b64_back.sv =====
// Back end of the Base64 codec: expands queued commands into words, one
// per cycle unless stalled, via an output register. Depends on b64_pkg.
`default_nettype none

module b64_back (
  input  wire              clk,
  input  wire              rst_n,
  input  b64_pkg::cmd_t    head,
  input  wire              empty,
  output logic             pop,
  output logic             out_valid,
  input  wire              out_ready,
  output logic [7:0]       out_data,
  output logic             out_last,
  output logic             out_bad
);

  logic       valid_r, valid_nxt;
  logic [7:0] data_r, data_nxt;
  logic       last_r, last_nxt;
  logic       bad_r, bad_nxt;
  logic [1:0] idx_r, idx_nxt;

  logic       load;
  logic       fire;
  logic [1:0] final_idx;
  logic       final_beat;
  logic       pad_beat;
  logic [5:0] sext;

  assign load = !valid_r || out_ready;
  assign fire = load && !empty;

  always_comb begin
    case (head.kind)
      b64_pkg::KIND_ENC: final_idx = 2'd3;
      b64_pkg::KIND_DEC: final_idx = 2'd2 - head.pads;
      default:           final_idx = 2'd0;
    endcase
  end

  assign final_beat = (idx_r == final_idx);
  assign pop        = fire && final_beat;
  assign pad_beat   = (idx_r == 2'd3 && head.pads != 2'd0) ||
                      (idx_r == 2'd2 && head.pads == 2'd2);

  always_comb begin
    case (idx_r)
      2'd0:    sext = head.bits[23:18];
      2'd1:    sext = head.bits[17:12];
      2'd2:    sext = head.bits[11:6];
      default: sext = head.bits[5:0];
    endcase
  end

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    last_nxt  = last_r;
    bad_nxt   = bad_r;
    idx_nxt   = idx_r;
    if (load) begin
      valid_nxt = !empty;
    end
    if (fire) begin
      last_nxt = head.last && final_beat;
      bad_nxt  = 1'b0;
      case (head.kind)
        b64_pkg::KIND_ENC: begin
          data_nxt = pad_beat ? b64_pkg::CHAR_PAD : b64_pkg::char_of(sext);
        end
        b64_pkg::KIND_DEC: begin
          case (idx_r)
            2'd0:    data_nxt = head.bits[23:16];
            2'd1:    data_nxt = head.bits[15:8];
            default: data_nxt = head.bits[7:0];
          endcase
        end
        default: begin
          data_nxt = 8'd0;
          bad_nxt  = 1'b1;
        end
      endcase
      idx_nxt = final_beat ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    last_r <= last_nxt;
    bad_r  <= bad_nxt;
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;
  assign out_last  = last_r;
  assign out_bad   = bad_r;

  // A command being expanded stays at the queue head until its last word.
  a_head_held: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r != 2'd0 |-> !empty)
    else $error("command left the queue mid-expansion");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && bad_r |-> data_r == 8'd0)
    else $error("bad word carries data");

endmodule

`default_nettype wire

// ===== rtl/base64_codec_core.sv =====
// Top level of the streaming Base64 codec (standard alphabet, '=' pad).
// Depends on b64_pkg, b64_front, b64_queue and b64_back.
//
//   Channel  Direction  Handshake             Word
//   in_      slave      in_tvalid/in_tready   tdata[7:0] byte or char, tlast end
//   out_     master     out_tvalid/out_tready tdata[7:0] char or byte, tlast end,
//                                             tuser[0] bad input
//   cfg_     write      cfg_wr_en             cfg_wr_data[0] mode (1 decodes)
//
// The front takes one input word per cycle while the two-entry command queue
// has room; the back drives one result word per cycle from the queue head
// while the output is ready. Encoding is thus bound by the single output
// port and decoding by the input port.
// Reset (synchronous, rst_n low) empties the queue, the output register and
// the partial group, and selects encoding. A mode write also drops a group.
// Output stalls back up through the queue; the front stalls only when full.
`default_nettype none

module base64_codec_core (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_tvalid,
  output logic       in_tready,
  input  wire  [7:0] in_tdata,   // [7:0] data_in
  input  wire        in_tlast,
  output logic       out_tvalid,
  input  wire        out_tready,
  output logic [7:0] out_tdata,  // [7:0] data_out
  output logic       out_tlast,
  output logic [0:0] out_tuser,  // [0] bad_input
  input  wire        cfg_wr_en,
  input  wire        cfg_wr_data
);

  logic          mode_r;
  logic          push;
  logic          pop;
  logic          q_empty;
  logic          q_full;
  b64_pkg::cmd_t push_cmd;
  b64_pkg::cmd_t head;

  // Hold the mode until the next write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= b64_pkg::MODE_ENCODE;
    end else if (cfg_wr_en) begin
      mode_r <= cfg_wr_data;
    end
  end

  // Gather groups and classify each finished group into a command.
  b64_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .mode     (mode_r),
    .clr      (cfg_wr_en),
    .in_valid (in_tvalid),
    .in_data  (in_tdata),
    .in_last  (in_tlast),
    .q_full   (q_full),
    .in_ready (in_tready),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // Decouple the two sides so each can stall on its own.
  b64_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  // Expand commands into result words.
  b64_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .empty     (q_empty),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_last  (out_tlast),
    .out_bad   (out_tuser[0])
  );

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking bench for base64_codec_core: encode and decode streams with
// random gaps on both channels, checked word by word against a local model.
// Depends on b64_pkg and the base64_codec_core RTL.
`timescale 1ns / 1ps

module testbench;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       bad;
  } codec_word_t;

  // Predicts the codec output for every accepted input word and holds the
  // expected words in arrival order.
  class codec_scoreboard;
    logic          mode;
    logic [17:0]   held_bits;
    logic [1:0]    group_fill;
    logic [1:0]    pad_seen;
    codec_word_t   expected_words[$];
    int            errors;

    function new();
      errors = 0;
      set_mode(b64_pkg::MODE_ENCODE);
    endfunction

    function void clear_group();
      held_bits  = '0;
      group_fill = '0;
      pad_seen   = '0;
    endfunction

    function void set_mode(logic m);
      mode = m;
      clear_group();
    endfunction

    static function logic [7:0] sextet_char(logic [5:0] v);
      string abc = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
      return abc[v];
    endfunction

    // Bit 6 set when the character is outside the alphabet.
    static function logic [6:0] char_sextet(logic [7:0] c);
      for (int i = 0; i < 64; i++) begin
        if (sextet_char(i[5:0]) == c) return {1'b0, i[5:0]};
      end
      return 7'h40;
    endfunction

    function void push(logic [7:0] d, logic l, logic b);
      codec_word_t w;
      w.data = d;
      w.last = l;
      w.bad  = b;
      expected_words.push_back(w);
    endfunction

    function void note_word(logic [7:0] d, logic l);
      logic [23:0] t;
      logic [6:0]  s;
      logic [5:0]  val;
      logic [1:0]  pos;
      logic [1:0]  pads;
      logic        ok;
      int          cnt;
      if (mode == b64_pkg::MODE_ENCODE) begin
        if (group_fill == 2'd2) begin
          t = {held_bits[15:0], d};
          cnt = 0;
        end else if (l) begin
          if (group_fill == 2'd0) begin
            t = {d, 16'h0000};
            cnt = 2;
          end else begin
            t = {held_bits[7:0], d, 8'h00};
            cnt = 1;
          end
        end else begin
          held_bits  = {held_bits[9:0], d};
          group_fill = group_fill + 2'd1;
          return;
        end
        for (int i = 0; i < 4; i++) begin
          push((i < 4 - cnt) ? sextet_char(t[23 - 6 * i -: 6]) : b64_pkg::CHAR_PAD,
               (i == 3) ? l : 1'b0, 1'b0);
        end
        clear_group();
      end else begin
        pos  = group_fill;
        pads = pad_seen;
        s    = char_sextet(d);
        if (d == b64_pkg::CHAR_PAD) begin
          // pad is legal only in the third or fourth place
          ok   = (pos >= 2'd2);
          pads = pads + 2'd1;
          val  = '0;
        end else begin
          ok  = !s[6] && (pads == 2'd0);
          val = s[5:0];
        end
        if (!ok) begin
          push(8'h00, l, 1'b1);
          clear_group();
        end else if (pos == 2'd3) begin
          // bits under the pads are dropped without a check
          t   = {held_bits, val};
          cnt = 3 - int'(pads);
          for (int i = 0; i < cnt; i++) begin
            push(t[23 - 8 * i -: 8], (i == cnt - 1) ? l : 1'b0, 1'b0);
          end
          clear_group();
        end else if (l) begin
          // message ends inside a group
          push(8'h00, 1'b1, 1'b1);
          clear_group();
        end else begin
          held_bits  = {held_bits[11:0], val};
          group_fill = pos + 2'd1;
          pad_seen   = pads;
        end
      end
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_word(logic [7:0] d, logic l, logic b);
      codec_word_t w;
      if (expected_words.size() == 0) begin
        report($sformatf("unexpected word data=%h last=%b bad=%b", d, l, b));
        return;
      end
      w = expected_words.pop_front();
      if (d !== w.data) report($sformatf("data %h, expected %h", d, w.data));
      if (l !== w.last) report($sformatf("last %b, expected %b", l, w.last));
      if (b !== w.bad)  report($sformatf("bad %b, expected %b", b, w.bad));
    endtask

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;   // [7:0] data_in
  logic       in_tlast;
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;  // [7:0] data_out
  logic       out_tlast;
  logic [0:0] out_tuser;  // [0] bad_input
  logic       cfg_wr_en;
  logic       cfg_wr_data;

  codec_scoreboard sb = new();
  logic [7:0]      msg_q[$];
  int              items_accepted = 0;
  bit              idle_on = 1'b1;

  base64_codec_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watch all three ports at each edge; values read here are the ones the
  // block saw, since every driver updates through nonblocking assignments.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_wr_en) sb.set_mode(cfg_wr_data);
      if (in_tvalid && in_tready) begin
        sb.note_word(in_tdata, in_tlast);
        items_accepted++;
      end
      if (out_tvalid && out_tready) sb.check_word(out_tdata, out_tlast, out_tuser[0]);
    end
  end

  // Receiver: hold ready low in short bursts while idling is enabled.
  initial begin
    logic v;
    int   len;
    forever begin
      if (idle_on && $urandom_range(0, 4) == 0) begin
        v   = 1'b0;
        len = $urandom_range(1, 8);
      end else begin
        v   = 1'b1;
        len = $urandom_range(1, 12);
      end
      out_tready <= v;
      repeat (len) @(posedge clk);
    end
  end

  // Offer one word and hold it until the handshake completes.
  task send_word(logic [7:0] d, logic l);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tlast  <= l;
    do @(posedge clk); while (!in_tready);
  endtask

  task send_msg(bit with_last);
    for (int i = 0; i < msg_q.size(); i++) begin
      send_word(msg_q[i], with_last && (i == msg_q.size() - 1));
    end
  endtask

  task send_text(string s, bit with_last);
    msg_q.delete();
    for (int i = 0; i < s.len(); i++) msg_q.push_back(s[i]);
    send_msg(with_last);
  endtask

  // Drop valid, let the monitor note the final word, wait for every
  // expected word, then let the front settle.
  task drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task write_mode(logic m);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Append the Base64 text of nbytes random bytes to msg_q.
  task add_encoding(int nbytes);
    logic [23:0] t;
    int          n;
    for (int g = 0; g < nbytes; g += 3) begin
      n = (nbytes - g > 3) ? 3 : nbytes - g;
      t = {8'($urandom), (n > 1) ? 8'($urandom) : 8'h00, (n > 2) ? 8'($urandom) : 8'h00};
      for (int i = 0; i < 4; i++) begin
        msg_q.push_back((i <= n) ? codec_scoreboard::sextet_char(t[23 - 6 * i -: 6])
                                 : b64_pkg::CHAR_PAD);
      end
    end
  endtask

  function logic [7:0] noise_char();
    case ($urandom_range(0, 2))
      0:       return b64_pkg::CHAR_PAD;
      1:       return codec_scoreboard::sextet_char(6'($urandom));
      default: return 8'($urandom);
    endcase
  endfunction

  task encode_message();
    int  n;
    bit  with_last;
    n = $urandom_range(1, 10);
    with_last = ($urandom_range(0, 4) != 0);
    msg_q.delete();
    repeat (n) msg_q.push_back(8'($urandom));
    send_msg(with_last);
  endtask

  task decode_message();
    int  pick;
    int  p;
    pick = $urandom_range(0, 99);
    msg_q.delete();
    if (pick < 55) begin
      add_encoding($urandom_range(1, 9));
    end else if (pick < 68) begin
      // padded group mid-message when the first length is not a multiple of three
      add_encoding($urandom_range(1, 5));
      add_encoding($urandom_range(1, 6));
    end else if (pick < 83) begin
      add_encoding($urandom_range(1, 9));
      p = $urandom_range(0, msg_q.size() - 1);
      msg_q[p] = noise_char();
    end else if (pick < 91) begin
      // cut a group short
      add_encoding($urandom_range(1, 9));
      repeat ($urandom_range(1, 3)) void'(msg_q.pop_back());
    end else begin
      repeat ($urandom_range(1, 8)) msg_q.push_back(noise_char());
    end
    send_msg($urandom_range(0, 9) != 0);
  endtask

  // Run limit
  initial begin
    #5ms;
    $display("testbench NOT OK");
    $finish;
  end

  initial begin
    logic m;
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= 8'h00;
    in_tlast    <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Encode out of reset: two pads, full group with '+' and '/', one pad.
    msg_q = '{8'h00};
    send_msg(1'b1);
    msg_q = '{8'hFB, 8'hFF, 8'hBF};
    send_msg(1'b1);
    msg_q = '{8'hFF, 8'h00};
    send_msg(1'b1);
    // Leave a partial group behind; the mode write must drop it.
    msg_q = '{8'h4D};
    send_msg(1'b0);
    drain();
    write_mode(b64_pkg::MODE_DECODE);

    // Decode: padded group mid-message then a full group.
    send_text("TQ==TWFu", 1'b1);
    // Invalid characters, pads too early, text after a pad.
    msg_q = '{8'h41, 8'hFF};
    send_msg(1'b0);
    send_text("=", 1'b0);
    send_text("A=", 1'b0);
    send_text("AB=C", 1'b0);
    // Short final group, then a null character ending the message.
    send_text("z9", 1'b1);
    msg_q = '{8'h00};
    send_msg(1'b1);
    drain();

    // Random phases, each under a freshly written mode.
    while (items_accepted < 390) begin
      m = $urandom_range(0, 1);
      write_mode(m);
      repeat ($urandom_range(3, 8)) begin
        if (m == b64_pkg::MODE_ENCODE) encode_message();
        else decode_message();
        if (items_accepted >= 310) idle_on = 1'b0;
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (sb.pending() != 0) sb.report($sformatf("%0d words never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
